// ===== design/wls_pkg.sv =====
// shared widths and codes for the weighted light sampler
package wls_pkg;

  localparam int WEIGHT_BITS   = 16;
  localparam int FRACTION_BITS = 16;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int IDX_W         = 8;
  localparam int PROB_W        = FRACTION_BITS + 1;

  // input tdata: weight, entry_virtual, random_fraction from bit 0 up
  localparam int IN_DATA_W  = 40;
  // output tdata: light_index, remapped_fraction, probability from bit 0 up
  localparam int OUT_DATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ZERO_W = 2'd3
  } status_e;

  localparam logic CFG_IDX_INCLUDE_VIRTUAL = 1'b0;

endpackage

// ===== design/wls_div.sv =====
// restoring divider, one quotient bit per cycle, for quotients below 2^(QW)
module wls_div #(
  parameter int NW = 41,
  parameter int DW = 25,
  parameter int QW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quotient_o
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [NW-1:0]    rem_q;
  logic [NW-1:0]    den_q;
  logic [QW-1:0]    quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             ge;

  assign ge         = (rem_q >= den_q);
  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QW);
      rem_q  <= dividend_i;
      // divisor aligned to the top quotient bit
      den_q  <= NW'(divisor_i) << (QW - 1);
      quo_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        if (ge) begin
          rem_q <= rem_q - den_q;
        end
        quo_q <= {quo_q[QW-2:0], ge};
        den_q <= den_q >> 1;
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/weighted_light_sampler.sv =====
// load and clear skip the walk and the divider; a sample with a nonzero total runs the
// one-entry-per-cycle prefix walk over the weight memory and, for a nonzero chosen weight,
// the shared bit-serial divider (remapped fraction, then probability); one item at a time.
// a finished item waits in the output register while the next item is taken.
// reset empties the table (count and total to zero) and clears include_virtual;
// the weight memory is not cleared; only entries below the count are used.
module weighted_light_sampler
  import wls_pkg::*;
#(
  parameter int MAX_LIGHTS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // stream in
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // weight, entry_virtual, random_fraction
  input  logic [OP_W-1:0]       s_axis_tuser_i,   // op
  // stream out
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // light_index, remapped_fraction, probability
  output logic [STATUS_W-1:0]   m_axis_tuser_o,   // status
  // register port
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [2:0]            paddr_i,
  input  logic [31:0]           pwdata_i,
  output logic [31:0]           prdata_o,
  output logic                  pready_o
);

  localparam int IW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int CW = $clog2(MAX_LIGHTS + 1);
  localparam int TW = WEIGHT_BITS + CW;
  localparam int NW = TW + FRACTION_BITS;
  localparam int QW = FRACTION_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_WALK,
    S_FRAC_GO,
    S_FRAC_WAIT,
    S_PROB_GO,
    S_PROB_WAIT,
    S_DONE
  } state_e;

  state_e state_q;

  logic                   include_virtual_q;
  logic [CW-1:0]          count_q;
  logic [TW-1:0]          total_q;
  logic [FRACTION_BITS-1:0] r_q;
  logic [NW-1:0]          scaled_q;
  logic [TW-1:0]          sum_q;
  logic [IW-1:0]          idx_q;
  logic [WEIGHT_BITS-1:0] w_q;

  logic [STATUS_W-1:0]      res_status_q;
  logic [IDX_W-1:0]         res_idx_q;
  logic [FRACTION_BITS-1:0] res_frac_q;
  logic [PROB_W-1:0]        res_prob_q;

  logic                     m_valid_q;
  logic [STATUS_W-1:0]      m_status_q;
  logic [IDX_W-1:0]         m_idx_q;
  logic [FRACTION_BITS-1:0] m_frac_q;
  logic [PROB_W-1:0]        m_prob_q;

  // weight memory
  logic [WEIGHT_BITS-1:0] mem [MAX_LIGHTS];
  logic [WEIGHT_BITS-1:0] rd_data_q;
  logic [IW-1:0]          rd_addr;
  logic                   mem_we;

  // input fields
  op_e                      in_op;
  logic [WEIGHT_BITS-1:0]   in_weight;
  logic                     in_virtual;
  logic [FRACTION_BITS-1:0] in_frac;
  logic                     in_fire;

  assign in_op      = op_e'(s_axis_tuser_i);
  assign in_weight  = s_axis_tdata_i[WEIGHT_BITS-1:0];
  assign in_virtual = s_axis_tdata_i[WEIGHT_BITS];
  assign in_frac    = s_axis_tdata_i[WEIGHT_BITS+1 +: FRACTION_BITS];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign mem_we = in_fire && (in_op == OP_LOAD) && !(in_virtual && !include_virtual_q)
                  && (count_q != CW'(MAX_LIGHTS));

  // walk reads one entry ahead of the compare
  assign rd_addr = (state_q == S_WALK) ? idx_q + IW'(1) : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IW-1:0]] <= in_weight;
    end
    rd_data_q <= mem[rd_addr];
  end

  // walk step
  logic [TW-1:0] sum_new;
  logic [CW-1:0] idx_inc;
  logic          walk_stop;

  assign sum_new   = sum_q + TW'(rd_data_q);
  assign idx_inc   = CW'(idx_q) + CW'(1);
  assign walk_stop = !(scaled_q > {sum_new, {FRACTION_BITS{1'b0}}}) || (idx_inc >= count_q);

  // remap numerator: scaled fraction past the start of the chosen span
  logic [NW-1:0] span_base;
  logic [NW-1:0] remap_num;

  assign span_base = {sum_q - TW'(w_q), {FRACTION_BITS{1'b0}}};
  assign remap_num = (scaled_q > span_base) ? scaled_q - span_base : '0;

  // shared divider
  logic          div_start;
  logic [NW-1:0] div_dividend;
  logic [TW-1:0] div_divisor;
  logic          div_done;
  logic [QW-1:0] div_quo;

  assign div_start    = (state_q == S_FRAC_GO) || (state_q == S_PROB_GO);
  assign div_dividend = (state_q == S_FRAC_GO) ? remap_num
                                               : {TW'(w_q), {FRACTION_BITS{1'b0}}};
  assign div_divisor  = (state_q == S_FRAC_GO) ? TW'(w_q) : total_q;

  wls_div #(
    .NW (NW),
    .DW (TW),
    .QW (QW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      total_q      <= '0;
      r_q          <= '0;
      scaled_q     <= '0;
      sum_q        <= '0;
      idx_q        <= '0;
      w_q          <= '0;
      res_status_q <= '0;
      res_idx_q    <= '0;
      res_frac_q   <= '0;
      res_prob_q   <= '0;
      m_valid_q    <= 1'b0;
      m_status_q   <= '0;
      m_idx_q      <= '0;
      m_frac_q     <= '0;
      m_prob_q     <= '0;
    end else begin
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            res_status_q <= ST_OK;
            res_idx_q    <= '0;
            res_frac_q   <= '0;
            res_prob_q   <= '0;
            state_q      <= S_DONE;
            unique case (in_op)
              OP_LOAD: begin
                if (in_virtual && !include_virtual_q) begin
                  res_status_q <= ST_OK;
                end else if (count_q == CW'(MAX_LIGHTS)) begin
                  res_status_q <= ST_FULL;
                end else begin
                  res_idx_q <= IDX_W'(count_q);
                  total_q   <= total_q + TW'(in_weight);
                  count_q   <= count_q + CW'(1);
                end
              end
              OP_CLEAR: begin
                count_q <= '0;
                total_q <= '0;
              end
              OP_SAMPLE: begin
                if (count_q == '0 || total_q == '0) begin
                  res_status_q <= ST_EMPTY;
                end else begin
                  r_q     <= in_frac;
                  state_q <= S_SCALE;
                end
              end
              default: ;
            endcase
          end
        end

        S_SCALE: begin
          scaled_q <= NW'(r_q) * NW'(total_q);
          sum_q    <= '0;
          idx_q    <= '0;
          state_q  <= S_WALK;
        end

        S_WALK: begin
          sum_q <= sum_new;
          if (walk_stop) begin
            w_q       <= rd_data_q;
            res_idx_q <= IDX_W'(idx_q);
            if (rd_data_q == '0) begin
              res_status_q <= ST_ZERO_W;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_FRAC_GO;
            end
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end

        S_FRAC_GO: begin
          state_q <= S_FRAC_WAIT;
        end

        S_FRAC_WAIT: begin
          if (div_done) begin
            // saturate to just below one
            res_frac_q <= div_quo[QW-1] ? {FRACTION_BITS{1'b1}}
                                        : div_quo[FRACTION_BITS-1:0];
            state_q    <= S_PROB_GO;
          end
        end

        S_PROB_GO: begin
          state_q <= S_PROB_WAIT;
        end

        S_PROB_WAIT: begin
          if (div_done) begin
            res_prob_q   <= PROB_W'(div_quo);
            res_status_q <= ST_OK;
            state_q      <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            m_valid_q  <= 1'b1;
            m_status_q <= res_status_q;
            m_idx_q    <= res_idx_q;
            m_frac_q   <= res_frac_q;
            m_prob_q   <= res_prob_q;
            state_q    <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({m_prob_q, m_frac_q, m_idx_q});

  // register port
  logic cfg_write;
  assign cfg_write = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      include_virtual_q <= 1'b0;
    end else if (cfg_write && (paddr_i[2] == CFG_IDX_INCLUDE_VIRTUAL)) begin
      include_virtual_q <= pwdata_i[0];
    end
  end

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == CFG_IDX_INCLUDE_VIRTUAL) ? {31'd0, include_virtual_q}
                                                            : 32'd0;

endmodule
